>>> rtl/assert_macros.svh
// Assertion macros for the RTL modules; sctt_engine uses them.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on clk_i, off while rst_ni is low.
`define SCTT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define SCTT_ASSERT_IMPLY(label, ante, cons) \
  `SCTT_ASSERT(label, (ante) |-> (cons))

// Next-cycle implication.
`define SCTT_ASSERT_NEXT(label, ante, cons) \
  `SCTT_ASSERT(label, (ante) |=> (cons))

`endif

>>> rtl/sctt_pkg.sv
// Package for the session close timer table: widths, codes and defaults.
// No dependencies.
package sctt_pkg;

  localparam int unsigned SESSIONS_DEF   = 1024;
  localparam int unsigned COUNT_W        = 32;
  localparam int unsigned ENTRY_W        = COUNT_W + 1;
  localparam int unsigned SID_W          = 10;
  localparam int unsigned APB_ADDR_W     = 2;
  localparam int unsigned APB_DATA_W     = 32;
  localparam logic [COUNT_W-1:0] RELOAD_RST = 32'd1000;

  localparam logic [APB_ADDR_W-1:0] REG_RELOAD_ADDR = 2'd0;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_ARM  = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_SCAN  = 3'b100
  } eng_state_e;

endpackage

>>> rtl/sctt_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module sctt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sctt_apb.sv
// APB register block holding the timer reload value.
// Depends on sctt_pkg.
module sctt_apb
  import sctt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [COUNT_W-1:0]    reload_o
);

  logic [COUNT_W-1:0] reload_q;
  logic [COUNT_W-1:0] reload_d;
  logic               hit;

  assign hit = (paddr == REG_RELOAD_ADDR);

  always_comb begin
    reload_d = reload_q;
    if (psel && penable && pwrite && hit) begin
      reload_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= RELOAD_RST;
    end else begin
      reload_q <= reload_d;
    end
  end

  assign prdata   = hit ? reload_q : '0;
  assign pready   = 1'b1;
  assign reload_o = reload_q;

endmodule

>>> rtl/sctt_engine.sv
// Request sequencer: clearing pass, arm writes, scan read-modify-write, result register.
// Depends on sctt_pkg and assert_macros.svh; drives the timer RAM port.
`include "assert_macros.svh"

module sctt_engine
  import sctt_pkg::*;
#(
  parameter int unsigned SESSIONS = SESSIONS_DEF,
  localparam int unsigned PTR_W   = $clog2(SESSIONS)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               opcode_i,
  input  logic [SID_W-1:0]   session_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SID_W-1:0]   released_session_o,
  input  logic [COUNT_W-1:0] reload_i,
  output logic               mem_we_o,
  output logic [PTR_W-1:0]   mem_addr_o,
  output logic [ENTRY_W-1:0] mem_wdata_o,
  input  logic [ENTRY_W-1:0] mem_rdata_i
);

  localparam logic [PTR_W-1:0] LAST = PTR_W'(SESSIONS - 1);

  eng_state_e         state_q, state_d;
  logic [PTR_W-1:0]   ptr_q, ptr_d;
  logic [PTR_W-1:0]   clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  logic [SID_W-1:0]   rel_q, rel_d;

  logic               acc;
  logic               sid_ok;
  logic               ent_act;
  logic [COUNT_W-1:0] ent_cnt;
  logic               release_now;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign sid_ok      = (32'(session_id_i) < 32'(SESSIONS));
  assign ent_act     = mem_rdata_i[ENTRY_W-1];
  assign ent_cnt     = mem_rdata_i[COUNT_W-1:0];
  assign release_now = (state_q == S_SCAN) && ent_act && (ent_cnt == '0);

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    clr_d       = clr_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = ptr_q;
    mem_wdata_o = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc) begin
          if (opcode_i == OP_ARM) begin
            mem_we_o    = sid_ok;
            mem_addr_o  = PTR_W'(session_id_i);
            mem_wdata_o = {1'b1, reload_i};
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_we_o    = ent_act;
        mem_wdata_o = (ent_cnt != '0) ? {1'b1, ent_cnt - 1'b1} : '0;
        ptr_d       = (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    rel_d       = rel_q;
    if (release_now) begin
      out_valid_d = 1'b1;
      rel_d       = SID_W'(ptr_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q <= rel_d;
  end

  assign out_valid_o        = out_valid_q;
  assign released_session_o = rel_q;

  `SCTT_ASSERT_IMPLY(a_scan_slot_free, state_q == S_SCAN, !out_valid_q)
  `SCTT_ASSERT_NEXT(a_scan_follows, acc && (opcode_i == OP_SCAN), state_q == S_SCAN)
  `SCTT_ASSERT_NEXT(a_ptr_hold, state_q != S_SCAN, $stable(ptr_q))
  `SCTT_ASSERT_IMPLY(a_result_from_scan, $rose(out_valid_q), $past(state_q == S_SCAN))

endmodule

>>> rtl/session_close_timer_table.sv
// Top level of the session close timer table: APB registers, sequencer, timer RAM.
// Depends on sctt_pkg, sctt_apb, sctt_engine and sctt_ram.
//
//  Channel  Handshake                  Payload
//  in       in_valid_i / in_ready_o    opcode_i, session_id_i
//  out      out_valid_o / out_ready_i  released_session_o
//  cfg      APB psel/penable/pready    paddr, pwdata, prdata (reload at 0x0)
//
// An arm request is a single RAM write; a scan tick reads the entry at the scan pointer
// and writes it back through the single RAM port, and no request is taken until it is done.
// After reset a clearing pass writes every entry, with in_ready_o low.
// A pending result holds out_valid_o; new requests are taken only once the
// result register is free or being emptied in the same cycle.
module session_close_timer_table
  import sctt_pkg::*;
#(
  parameter int unsigned SESSIONS = SESSIONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [SID_W-1:0]      session_id_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SID_W-1:0]      released_session_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W = $clog2(SESSIONS);

  logic [COUNT_W-1:0] reload;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  sctt_apb u_apb (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .reload_o (reload)
  );

  sctt_engine #(
    .SESSIONS (SESSIONS)
  ) u_engine (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .session_id_i       (session_id_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .released_session_o (released_session_o),
    .reload_i           (reload),
    .mem_we_o           (mem_we),
    .mem_addr_o         (mem_addr),
    .mem_wdata_o        (mem_wdata),
    .mem_rdata_i        (mem_rdata)
  );

  sctt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SESSIONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
